### sv/wsfd_pkg.sv
// Package with the types and constants shared by the WebSocket deframer modules.
`default_nettype none

package wsfd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

    localparam logic [7:0] HDR_FIN_BIT  = 8'h80;
    localparam logic [7:0] HDR_MASK_BIT = 8'h80;
    localparam logic [6:0] LEN7_EXT16   = 7'd126;
    localparam logic [6:0] LEN7_EXT64   = 7'd127;

    typedef enum logic [3:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR1_NOTFIN,
        PH_EXT_HI,
        PH_EXT_LO,
        PH_MASK0,
        PH_MASK1,
        PH_MASK2,
        PH_MASK3,
        PH_PAYLOAD,
        PH_DROP
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_EMPTY,
        KIND_ERROR
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_NOT_FINAL,
        ERR_UNMASKED,
        ERR_LEN64,
        ERR_TOO_LONG
    } t_err;

    typedef struct packed {
        logic       session_start;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [3:0]  frame_opcode;
        logic [15:0] frame_len;
        logic        last;
        t_err        error_code;
    } t_out_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  raw_byte;
        logic [7:0]  mask_byte;
        logic [3:0]  opcode;
        logic [15:0] frame_len;
        logic        last;
        t_err        error_code;
    } t_cmd;

endpackage

`default_nettype wire

### sv/websocket_frame_deframer_unit.sv
// Top level of the WebSocket frame deframer: parser, command queue and result stage.
// A byte's result is written into the command queue and then into the result register before it reaches the output.
// Throughput: one received byte per cycle while the queue is not full; the header parser takes each accepted byte.
// The queue lets the parser keep taking bytes while a result waits to be popped.
// Reset is synchronous and active low; it clears the parser to header byte zero,
// empties the queue and sets the maximum payload length to 4096.
`default_nettype none

module websocket_frame_deframer_unit
    import wsfd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_in,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    logic w_accept;
    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_take;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = push & ~full;

    wsfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_item      (i_in),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    wsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_cmd   (w_cmd),
        .o_full  (full),
        .i_pop   (w_take),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    wsfd_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_take      (w_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out)
    );

endmodule

`default_nettype wire

### sv/wsfd_parser.sv
// Header parser that classifies each received byte and issues result commands.
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_in_item    i_item,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd
);

    t_phase      r_phase;
    t_phase      n_phase;
    t_phase      w_phase;
    logic [15:0] r_max_len;
    logic [3:0]  r_opcode;
    logic [3:0]  n_opcode;
    logic [7:0]  r_ext_hi;
    logic [7:0]  n_ext_hi;
    logic [15:0] r_len;
    logic [15:0] n_len;
    logic [15:0] r_index;
    logic [15:0] n_index;
    logic [31:0] r_mask;
    logic [31:0] n_mask;

    logic [7:0]  w_byte;
    logic [6:0]  w_len7;
    logic [15:0] w_ext_len;
    logic [15:0] w_index_inc;
    logic        w_is_last;
    logic [7:0]  w_mask_byte;

    assign w_phase     = i_item.session_start ? PH_HDR0 : r_phase;
    assign w_byte      = i_item.in_byte;
    assign w_len7      = w_byte[6:0];
    assign w_ext_len   = {r_ext_hi, w_byte};
    assign w_index_inc = r_index + 16'd1;
    assign w_is_last   = (w_index_inc == r_len);

    always_comb begin
        unique case (r_index[1:0])
            2'd0: w_mask_byte = r_mask[31:24];
            2'd1: w_mask_byte = r_mask[23:16];
            2'd2: w_mask_byte = r_mask[15:8];
            default: w_mask_byte = r_mask[7:0];
        endcase
    end

    always_comb begin
        n_phase = w_phase;
        unique case (w_phase)
            PH_HDR0: begin
                n_phase = ((w_byte & HDR_FIN_BIT) != 8'd0) ? PH_HDR1 : PH_HDR1_NOTFIN;
            end
            PH_HDR1: begin
                priority if ((w_byte & HDR_MASK_BIT) == 8'd0) begin
                    n_phase = PH_DROP;
                end else if (w_len7 == LEN7_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else if (w_len7 == LEN7_EXT64) begin
                    n_phase = PH_DROP;
                end else if ({9'd0, w_len7} > r_max_len) begin
                    n_phase = PH_DROP;
                end else begin
                    n_phase = PH_MASK0;
                end
            end
            PH_HDR1_NOTFIN: n_phase = PH_DROP;
            PH_EXT_HI:      n_phase = PH_EXT_LO;
            PH_EXT_LO:      n_phase = (w_ext_len > r_max_len) ? PH_DROP : PH_MASK0;
            PH_MASK0:       n_phase = PH_MASK1;
            PH_MASK1:       n_phase = PH_MASK2;
            PH_MASK2:       n_phase = PH_MASK3;
            PH_MASK3:       n_phase = (r_len == 16'd0) ? PH_HDR0 : PH_PAYLOAD;
            PH_PAYLOAD:     n_phase = w_is_last ? PH_HDR0 : PH_PAYLOAD;
            default:        n_phase = PH_DROP;
        endcase
    end

    always_comb begin
        n_opcode    = r_opcode;
        n_ext_hi    = r_ext_hi;
        n_len       = r_len;
        n_index     = r_index;
        n_mask      = r_mask;
        o_cmd_valid = 1'b0;
        o_cmd       = '{kind: KIND_ERROR, raw_byte: 8'd0, mask_byte: 8'd0,
                        opcode: r_opcode, frame_len: 16'd0, last: 1'b0,
                        error_code: ERR_NONE};
        unique case (w_phase)
            PH_HDR0: begin
                n_opcode = w_byte[3:0];
            end
            PH_HDR1: begin
                priority if ((w_byte & HDR_MASK_BIT) == 8'd0) begin
                    o_cmd_valid      = 1'b1;
                    o_cmd.error_code = ERR_UNMASKED;
                end else if (w_len7 == LEN7_EXT16) begin
                    n_len = r_len;
                end else if (w_len7 == LEN7_EXT64) begin
                    o_cmd_valid      = 1'b1;
                    o_cmd.error_code = ERR_LEN64;
                end else if ({9'd0, w_len7} > r_max_len) begin
                    o_cmd_valid      = 1'b1;
                    o_cmd.error_code = ERR_TOO_LONG;
                end else begin
                    n_len  = {9'd0, w_len7};
                    n_mask = 32'd0;
                end
            end
            PH_HDR1_NOTFIN: begin
                o_cmd_valid      = 1'b1;
                o_cmd.error_code = ERR_NOT_FINAL;
            end
            PH_EXT_HI: begin
                n_ext_hi = w_byte;
            end
            PH_EXT_LO: begin
                if (w_ext_len > r_max_len) begin
                    o_cmd_valid      = 1'b1;
                    o_cmd.error_code = ERR_TOO_LONG;
                end else begin
                    n_len  = w_ext_len;
                    n_mask = 32'd0;
                end
            end
            PH_MASK0, PH_MASK1, PH_MASK2: begin
                n_mask = {r_mask[23:0], w_byte};
            end
            PH_MASK3: begin
                n_mask  = {r_mask[23:0], w_byte};
                n_index = 16'd0;
                if (r_len == 16'd0) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = KIND_EMPTY;
                    o_cmd.last  = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                o_cmd_valid     = 1'b1;
                o_cmd.kind      = KIND_DATA;
                o_cmd.raw_byte  = w_byte;
                o_cmd.mask_byte = w_mask_byte;
                o_cmd.frame_len = r_len;
                o_cmd.last      = w_is_last;
                n_index         = w_index_inc;
            end
            default: begin
                n_index = r_index;
            end
        endcase
        o_cmd_valid = o_cmd_valid & i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR0;
            r_max_len <= MAX_LEN_RESET;
            r_opcode  <= 4'd0;
            r_ext_hi  <= 8'd0;
            r_len     <= 16'd0;
            r_index   <= 16'd0;
            r_mask    <= 32'd0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            if (i_valid) begin
                r_phase  <= n_phase;
                r_opcode <= n_opcode;
                r_ext_hi <= n_ext_hi;
                r_len    <= n_len;
                r_index  <= n_index;
                r_mask   <= n_mask;
            end
        end
    end

endmodule

`default_nettype wire

### sv/wsfd_queue.sv
// Short command queue between the parser and the result stage.
`default_nettype none

module wsfd_queue
    import wsfd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_cmd          r_slots [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == FULL_COUNT);
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_slots[r_rd_ptr];
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + AW'(1);
            end
            unique case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/wsfd_result.sv
// Result stage that unmasks payload bytes and holds the oldest result for popping.
`default_nettype none

module wsfd_result
    import wsfd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_take,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    assign o_empty = ~r_valid;
    assign o_item  = r_item;
    assign o_take  = i_cmd_valid & (~r_valid | i_pop);

    always_comb begin
        n_item.kind         = i_cmd.kind;
        n_item.data_byte    = i_cmd.raw_byte ^ i_cmd.mask_byte;
        n_item.frame_opcode = i_cmd.opcode;
        n_item.frame_len    = i_cmd.frame_len;
        n_item.last         = i_cmd.last;
        n_item.error_code   = i_cmd.error_code;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### dv/tb_websocket_frame_deframer_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the WebSocket frame deframer top level: directed frames, then random byte streams.
module tb_websocket_frame_deframer_unit;
    import wsfd_pkg::*;

    typedef enum logic [1:0] {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } t_len_form;

    typedef struct packed {
        logic [3:0] gap;
        t_in_item   item;
    } t_byte_slot;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    t_in_item    i_in = '0;
    logic        empty;
    logic        pop = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    websocket_frame_deframer_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    t_phase      ph_now = PH_HDR0;
    logic [3:0]  hdr_opcode = '0;
    logic [7:0]  len_hi = '0;
    logic [15:0] frame_bytes = '0;
    logic [15:0] pay_index = '0;
    logic [31:0] mask_word = '0;
    logic [15:0] len_limit = MAX_LEN_RESET;

    t_out_item   pending_results[$];
    t_byte_slot  byte_slots[$];
    t_in_item    frame_buf[$];
    t_byte_slot  next_slot;

    int unsigned bytes_sent = 0;
    int unsigned bytes_taken = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;
    logic        slot_ready = 1'b0;
    logic        frame_rejected = 1'b0;
    logic        need_restart = 1'b0;
    logic        tx_gappy = 1'b1;
    logic        rx_gappy = 1'b1;

    always #5 i_clk = ~i_clk;

    function automatic void deframe_byte(t_in_item it);
        t_out_item   res;
        t_err        err;
        logic        emit;
        logic [7:0]  b;
        logic [15:0] ext_len;
        res = '0;
        err = ERR_NONE;
        emit = 1'b0;
        b = it.in_byte;
        if (it.session_start) ph_now = PH_HDR0;
        case (ph_now)
            PH_HDR0: begin
                hdr_opcode = b[3:0];
                ph_now = b[7] ? PH_HDR1 : PH_HDR1_NOTFIN;
            end
            PH_HDR1, PH_HDR1_NOTFIN: begin
                if (ph_now == PH_HDR1_NOTFIN) err = ERR_NOT_FINAL;
                else if (!b[7]) err = ERR_UNMASKED;
                else if (b[6:0] == LEN7_EXT16) ph_now = PH_EXT_HI;
                else if (b[6:0] == LEN7_EXT64) err = ERR_LEN64;
                else if ({9'd0, b[6:0]} > len_limit) err = ERR_TOO_LONG;
                else begin
                    frame_bytes = {9'd0, b[6:0]};
                    mask_word = '0;
                    ph_now = PH_MASK0;
                end
            end
            PH_EXT_HI: begin
                len_hi = b;
                ph_now = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                ext_len = {len_hi, b};
                if (ext_len > len_limit) begin
                    err = ERR_TOO_LONG;
                end else begin
                    frame_bytes = ext_len;
                    mask_word = '0;
                    ph_now = PH_MASK0;
                end
            end
            PH_MASK0, PH_MASK1, PH_MASK2: begin
                mask_word = {mask_word[23:0], b};
                ph_now = t_phase'(ph_now + 4'd1);
            end
            PH_MASK3: begin
                mask_word = {mask_word[23:0], b};
                pay_index = '0;
                if (frame_bytes == 16'd0) begin
                    ph_now = PH_HDR0;
                    res.kind = KIND_EMPTY;
                    res.frame_opcode = hdr_opcode;
                    res.last = 1'b1;
                    emit = 1'b1;
                end else begin
                    ph_now = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res.kind = KIND_DATA;
                res.data_byte = b ^ mask_word[8 * (3 - int'(pay_index[1:0])) +: 8];
                res.frame_opcode = hdr_opcode;
                res.frame_len = frame_bytes;
                res.last = (pay_index + 16'd1 == frame_bytes);
                emit = 1'b1;
                pay_index = pay_index + 16'd1;
                if (res.last) ph_now = PH_HDR0;
            end
            default: ;
        endcase
        if (err != ERR_NONE) begin
            ph_now = PH_DROP;
            res.kind = KIND_ERROR;
            res.frame_opcode = hdr_opcode;
            res.error_code = err;
            emit = 1'b1;
        end
        if (emit) pending_results.insert(pending_results.size(), res);
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 100) $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                      results_seen, got));
        end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                          results_seen, got.kind, want.kind));
            if (got.data_byte !== want.data_byte)
                report_mismatch($sformatf("result %0d data_byte %h, expected %h",
                                          results_seen, got.data_byte, want.data_byte));
            if (got.frame_opcode !== want.frame_opcode)
                report_mismatch($sformatf("result %0d frame_opcode %h, expected %h",
                                          results_seen, got.frame_opcode, want.frame_opcode));
            if (got.frame_len !== want.frame_len)
                report_mismatch($sformatf("result %0d frame_len %0d, expected %0d",
                                          results_seen, got.frame_len, want.frame_len));
            if (got.last !== want.last)
                report_mismatch($sformatf("result %0d last %b, expected %b",
                                          results_seen, got.last, want.last));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("result %0d error_code %0d, expected %0d",
                                          results_seen, got.error_code, want.error_code));
        end
    endtask

    task automatic add_byte(logic ss, logic [7:0] b);
        t_byte_slot s;
        s.gap = tx_gappy ? 4'($urandom_range(0, 8)) : 4'd0;
        s.item = t_in_item'({ss, b});
        byte_slots.insert(byte_slots.size(), s);
        bytes_sent++;
    endtask

    // A rejected header is cut short after the byte that the parser rejects.
    task automatic build_frame(logic ss, logic fin, logic masked, t_len_form form,
                               logic [3:0] opc, logic [15:0] len);
        int unsigned i;
        frame_buf.delete();
        frame_rejected = 1'b1;
        frame_buf.insert(frame_buf.size(),
                         t_in_item'({ss, fin, 3'($urandom_range(0, 7)), opc}));
        case (form)
            LEN_SHORT: frame_buf.insert(frame_buf.size(),
                                        t_in_item'({1'b0, masked, len[6:0]}));
            LEN_EXT16: frame_buf.insert(frame_buf.size(),
                                        t_in_item'({1'b0, masked, LEN7_EXT16}));
            default:   frame_buf.insert(frame_buf.size(),
                                        t_in_item'({1'b0, masked, LEN7_EXT64}));
        endcase
        if (fin && masked && form != LEN_EXT64) begin
            if (form == LEN_EXT16) begin
                frame_buf.insert(frame_buf.size(), t_in_item'({1'b0, len[15:8]}));
                frame_buf.insert(frame_buf.size(), t_in_item'({1'b0, len[7:0]}));
            end
            if (len <= len_limit) begin
                frame_rejected = 1'b0;
                for (i = 0; i < 4 + len; i++)
                    frame_buf.insert(frame_buf.size(),
                                     t_in_item'({1'b0, 8'($urandom_range(0, 255))}));
            end
        end
    endtask

    task automatic queue_frame(int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            add_byte(frame_buf[i].session_start, frame_buf[i].in_byte);
    endtask

    task automatic gen_random_frame();
        int unsigned pick;
        int unsigned size_pick;
        int unsigned n;
        int unsigned i;
        logic [15:0] len;
        t_len_form   form;
        logic        ss;
        logic        fin;
        logic        masked;
        pick = $urandom_range(0, 99);
        ss = need_restart || ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) == 0) tx_gappy = !tx_gappy;
        if (pick < 8) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                add_byte($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
            need_restart = 1'b1;
        end else begin
            size_pick = $urandom_range(0, 99);
            if (size_pick < 12) len = 16'd0;
            else if (size_pick < 70) len = 16'($urandom_range(1, 16));
            else if (size_pick < 85) len = 16'($urandom_range(17, 125));
            else if (size_pick < 95 || len_limit == 16'hFFFF) len = 16'($urandom_range(126, 300));
            else len = 16'($urandom_range(32'(len_limit) + 1, 65535));
            if (len > 16'd125 || $urandom_range(0, 7) == 0) form = LEN_EXT16;
            else form = LEN_SHORT;
            if ($urandom_range(0, 24) == 0) form = LEN_EXT64;
            fin = ($urandom_range(0, 19) != 0);
            masked = ($urandom_range(0, 19) != 0);
            build_frame(ss, fin, masked, form, 4'($urandom_range(0, 15)), len);
            if (pick < 16) begin
                queue_frame($urandom_range(1, frame_buf.size()));
                need_restart = 1'b1;
            end else begin
                queue_frame(frame_buf.size());
                need_restart = frame_rejected;
            end
        end
    endtask

    task automatic drain_results();
        while (bytes_taken != bytes_sent || pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        len_limit = value;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                deframe_byte(i_in);
                bytes_taken++;
            end
            if (!push || !full) begin
                if (!slot_ready && byte_slots.size() != 0) begin
                    next_slot = byte_slots.pop_front();
                    tx_wait = next_slot.gap;
                    slot_ready = 1'b1;
                end
                if (slot_ready && tx_wait == 0) begin
                    push <= 1'b1;
                    i_in <= next_slot.item;
                    slot_ready = 1'b0;
                end else begin
                    push <= 1'b0;
                    if (tx_wait > 0) tx_wait--;
                end
            end
        end
    end

    // The receiver stalls for a long stretch now and then so the block backs up into full.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                check_result(o_out);
                results_seen++;
                if ($urandom_range(0, 31) == 0) rx_gappy = !rx_gappy;
                if (results_seen % 300 == 40) rx_wait = 150;
                else if (rx_gappy) rx_wait = $urandom_range(0, 8);
                else rx_wait = 0;
            end
            if (rx_wait > 0) begin
                pop <= 1'b0;
                rx_wait--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned k;
        int unsigned start;
        logic [15:0] lim;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        build_frame(1'b1, 1'b1, 1'b1, LEN_SHORT, 4'h9, 16'd0);
        queue_frame(frame_buf.size());
        build_frame(1'b0, 1'b0, 1'b1, LEN_SHORT, 4'h1, 16'd5);
        queue_frame(frame_buf.size());
        build_frame(1'b1, 1'b1, 1'b0, LEN_SHORT, 4'h2, 16'd5);
        queue_frame(frame_buf.size());
        build_frame(1'b1, 1'b1, 1'b1, LEN_EXT64, 4'h8, 16'd0);
        queue_frame(frame_buf.size());
        build_frame(1'b1, 1'b1, 1'b1, LEN_EXT16, 4'hA, MAX_LEN_RESET + 16'd1);
        queue_frame(frame_buf.size());
        build_frame(1'b1, 1'b1, 1'b1, LEN_SHORT, 4'hF, 16'd3);
        queue_frame(frame_buf.size());

        for (k = 0; k < 6; k++) begin
            drain_results();
            case (k)
                0:       lim = 16'hFFFF;
                1:       lim = 16'd0;
                2:       lim = 16'd100;
                3:       lim = 16'd300;
                4:       lim = 16'($urandom_range(0, 65535));
                default: lim = MAX_LEN_RESET;
            endcase
            write_limit(lim);
            start = bytes_sent;
            while (bytes_sent - start < 175) gen_random_frame();
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_websocket_frame_deframer_unit: done, clean");
        end else begin
            $display("tb_websocket_frame_deframer_unit: done, errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_websocket_frame_deframer_unit: done, errors");
        $finish;
    end

endmodule

### websocket_frame_deframer_unit.f
sv/wsfd_pkg.sv
sv/wsfd_parser.sv
sv/wsfd_queue.sv
sv/wsfd_result.sv
sv/websocket_frame_deframer_unit.sv
dv/tb_websocket_frame_deframer_unit.sv
